[rtl/cssc_pkg.sv]
// Shared types and constants for the comment stripper and space collapser.
`timescale 1ns / 1ps

package cssc_pkg;

    // Character codes the scanner reacts to.
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_STAR      = 8'h2A;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_VTAB      = 8'h0B;
    localparam logic [7:0] CH_FORMFEED  = 8'h0C;
    localparam logic [7:0] CH_RETURN    = 8'h0D;

    // Step queue between the scanner and the output stage.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Scanner mode, one-hot.
    typedef enum logic [3:0] {
        MODE_LOOK   = 4'b0001,
        MODE_LINE   = 4'b0010,
        MODE_BLOCK  = 4'b0100,
        MODE_STRING = 4'b1000
    } t_mode;

    // Input beat.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in;

    // Output beat.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        logic       out_last;
    } t_out;

    // All results caused by one input byte: one or two output beats.
    typedef struct packed {
        t_out item0;
        t_out item1;
        logic two;
    } t_step;

endpackage

[rtl/cssc_front.sv]
// Scanner: accepts input bytes, tracks comment and string state, builds result steps.
`timescale 1ns / 1ps

module cssc_front import cssc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_in   i_in_data,
    input  logic  i_full,
    output logic  o_push,
    output t_step o_step
);

    t_mode      r_mode, n_mode;
    logic       r_gave, n_gave;
    logic       r_held, n_held;
    logic       r_star, n_star;
    logic       r_esc,  n_esc;

    logic [1:0] e_cnt;
    logic [7:0] e_b0;
    logic [7:0] e_b1;
    logic       do_look;
    logic       accept;
    logic [7:0] c;
    logic       c_ws;

    assign c      = i_in_data.in_byte;
    assign c_ws   = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NEWLINE) ||
                    (c == CH_VTAB) || (c == CH_FORMFEED) || (c == CH_RETURN);
    assign o_in_ready = !i_full;
    assign accept = i_in_valid && o_in_ready;

    // Next scanner state and the bytes this input emits.
    always_comb begin
        n_mode  = r_mode;
        n_gave  = r_gave;
        n_held  = r_held;
        n_star  = r_star;
        n_esc   = r_esc;
        e_cnt   = 2'd0;
        e_b0    = 8'h00;
        e_b1    = 8'h00;
        do_look = 1'b0;

        case (r_mode)
            MODE_LOOK: begin
                if (r_held) begin
                    n_held = 1'b0;
                    if (c == CH_SLASH) begin
                        n_mode = MODE_LINE;
                    end else if (c == CH_STAR) begin
                        n_mode = MODE_BLOCK;
                        n_star = 1'b0;
                    end else begin
                        e_b0    = CH_SLASH;
                        e_cnt   = 2'd1;
                        do_look = 1'b1;
                    end
                end else begin
                    do_look = 1'b1;
                end
            end
            MODE_LINE: begin
                if (c == CH_NEWLINE) begin
                    n_mode = MODE_LOOK;
                    if (!r_gave) begin
                        e_b0   = CH_SPACE;
                        e_cnt  = 2'd1;
                        n_gave = 1'b1;
                    end
                end
            end
            MODE_BLOCK: begin
                if (r_star && (c == CH_SLASH)) begin
                    n_mode = MODE_LOOK;
                    n_star = 1'b0;
                end else begin
                    n_star = (c == CH_STAR);
                end
            end
            MODE_STRING: begin
                e_b0  = c;
                e_cnt = 2'd1;
                if (r_esc) begin
                    n_esc = 1'b0;
                end else if (c == CH_BACKSLASH) begin
                    n_esc = 1'b1;
                end else if (c == CH_QUOTE) begin
                    n_mode = MODE_LOOK;
                end
            end
            default: begin
                n_mode = MODE_LOOK;
            end
        endcase

        // A byte seen while looking with no slash pending.
        if (do_look) begin
            if (c == CH_SLASH) begin
                n_held = 1'b1;
                n_gave = 1'b0;
            end else if (c_ws) begin
                if (!r_gave) begin
                    n_gave = 1'b1;
                    if (e_cnt == 2'd0) begin
                        e_b0 = CH_SPACE;
                    end else begin
                        e_b1 = CH_SPACE;
                    end
                    e_cnt = e_cnt + 2'd1;
                end
            end else begin
                n_gave = 1'b0;
                if (e_cnt == 2'd0) begin
                    e_b0 = c;
                end else begin
                    e_b1 = c;
                end
                e_cnt = e_cnt + 2'd1;
                if (c == CH_QUOTE) begin
                    n_mode = MODE_STRING;
                    n_esc  = 1'b0;
                end
            end
        end

        // The final byte flushes a pending slash and resets the scanner.
        if (i_in_data.in_last) begin
            if (n_held && (e_cnt != 2'd2)) begin
                if (e_cnt == 2'd0) begin
                    e_b0 = CH_SLASH;
                end else begin
                    e_b1 = CH_SLASH;
                end
                e_cnt = e_cnt + 2'd1;
            end
            n_mode = MODE_LOOK;
            n_gave = 1'b0;
            n_held = 1'b0;
            n_star = 1'b0;
            n_esc  = 1'b0;
        end
    end

    // Pack the emitted bytes into a step; the final step always carries a beat.
    always_comb begin
        o_step.item0 = '{out_byte: e_b0, out_valid: 1'b1, out_last: 1'b0};
        o_step.item1 = '{out_byte: e_b1, out_valid: 1'b1, out_last: 1'b0};
        o_step.two   = (e_cnt == 2'd2);
        if (i_in_data.in_last) begin
            if (e_cnt == 2'd0) begin
                o_step.item0 = '{out_byte: 8'h00, out_valid: 1'b0, out_last: 1'b1};
            end else if (e_cnt == 2'd1) begin
                o_step.item0.out_last = 1'b1;
            end else begin
                o_step.item1.out_last = 1'b1;
            end
        end
    end

    assign o_push = accept && ((e_cnt != 2'd0) || i_in_data.in_last);

    // Scanner state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_LOOK;
            r_gave <= 1'b0;
            r_held <= 1'b0;
            r_star <= 1'b0;
            r_esc  <= 1'b0;
        end else if (accept) begin
            r_mode <= n_mode;
            r_gave <= n_gave;
            r_held <= n_held;
            r_star <= n_star;
            r_esc  <= n_esc;
        end
    end

endmodule

[rtl/cssc_queue.sv]
// Small step queue that decouples the scanner from the output stage.
`timescale 1ns / 1ps

module cssc_queue import cssc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_step i_step,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_head_valid,
    output t_step o_head
);

    t_step                 r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW:0]     r_wr, n_wr;
    logic [QUEUE_AW:0]     r_rd, n_rd;

    assign o_full       = (r_wr[QUEUE_AW] != r_rd[QUEUE_AW]) &&
                          (r_wr[QUEUE_AW-1:0] == r_rd[QUEUE_AW-1:0]);
    assign o_head_valid = (r_wr != r_rd);
    assign o_head       = r_mem[r_rd[QUEUE_AW-1:0]];

    assign n_wr = r_wr + (QUEUE_AW+1)'(1);
    assign n_rd = r_rd + (QUEUE_AW+1)'(1);

    // Storage; the scanner never pushes while full.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr[QUEUE_AW-1:0]] <= i_step;
        end
    end

    // Pointers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
        end else begin
            if (i_push) begin
                r_wr <= n_wr;
            end
            if (i_pop) begin
                r_rd <= n_rd;
            end
        end
    end

endmodule

[rtl/cssc_back.sv]
// Output stage: unpacks queued steps into single beats behind an output register.
`timescale 1ns / 1ps

module cssc_back import cssc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_head_valid,
    input  t_step i_head,
    output logic  o_pop,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    output t_out  o_out_data
);

    logic r_valid, n_valid;
    t_out r_item,  n_item;
    logic r_sel,   n_sel;
    logic load;
    logic final_beat;

    assign load       = !r_valid || i_out_ready;
    assign final_beat = r_sel || !i_head.two;

    // Choose the next beat from the head step; pop once its last beat is loaded.
    always_comb begin
        n_valid = r_valid;
        n_item  = r_item;
        n_sel   = r_sel;
        o_pop   = 1'b0;
        if (load) begin
            n_valid = i_head_valid;
            if (i_head_valid) begin
                n_item = r_sel ? i_head.item1 : i_head.item0;
                o_pop  = final_beat;
                n_sel  = !final_beat;
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sel   <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_sel   <= n_sel;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_item;

endmodule

[rtl/comment_strip_space_collapse.sv]
// Top level of the streaming C comment stripper with whitespace collapsing.
`timescale 1ns / 1ps

// Takes source text one byte per beat and returns it with line and block
// comments removed and every whitespace run outside strings turned into one
// space; string literals, escapes included, pass unchanged. A beat with
// in_last set ends the text: a held slash is flushed, the final output beat
// carries out_last, and a bare end marker (out_valid low) is sent when that
// byte yields nothing. An input byte is accepted every cycle while the
// four-entry step queue has room; each byte yields zero, one or two output
// beats, and the output register drains one beat per cycle while
// i_out_ready is high. An input beat reaches its first output beat through
// the step queue and then the output register.
module comment_strip_space_collapse import cssc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    logic  push;
    logic  pop;
    logic  full;
    logic  head_valid;
    t_step step;
    t_step head;

    cssc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_full     (full),
        .o_push     (push),
        .o_step     (step)
    );

    cssc_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_step       (step),
        .i_pop        (pop),
        .o_full       (full),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    cssc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_data   (o_out_data)
    );

    // The output stage only pops a step that is present.
    assert property (@(posedge i_clk) disable iff (!i_rst_n) pop |-> head_valid)
        else $error("pop from an empty step queue");

    // The scanner never writes into a full queue.
    assert property (@(posedge i_clk) disable iff (!i_rst_n) push |-> !full)
        else $error("push into a full step queue");

    // A bare end marker is always the last beat of a text and carries a zero byte.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.out_valid) |->
            (o_out_data.out_last && (o_out_data.out_byte == 8'h00)))
        else $error("bare end marker without last flag or with a nonzero byte");

endmodule
